@@ design/adsn_pkg.sv @@
// Shared types and constants for the axis-aligned box distance / normal unit.
// Used by the top level, the pipelined square root and the pipelined divider.
package adsn_pkg;

	localparam int NAXES      = 3;
	localparam int CW         = 32;          // coordinate width, Q16.16
	localparam int NW         = 16;          // normal width, Q2.14
	localparam int NORM_SHIFT = 14;          // log2 of NORM_ONE
	localparam logic [NW-1:0] NORM_ONE = 16'd16384;
	localparam logic [4:0] NORM_MSB = 5'd20; // top bit of the largest scaled excess
	localparam int SC_W       = 21;          // scaled excess width

	// square root: 64-bit radicand, 32 digit steps, rounded 33-bit root
	localparam int SQ_IW = 64;
	localparam int SQ_H  = 32;

	// normal divider: 36-bit numerator, 22-bit length, 16 quotient bits
	localparam int DIV_NW = 36;
	localparam int DIV_DW = 22;
	localparam int DIV_QW = 16;

	typedef enum logic [2:0] {
		REG_MIN_X = 3'd0,
		REG_MIN_Y = 3'd1,
		REG_MIN_Z = 3'd2,
		REG_MAX_X = 3'd3,
		REG_MAX_Y = 3'd4,
		REG_MAX_Z = 3'd5
	} reg_idx_t;

	// per-item results that ride alongside the long arithmetic stages
	typedef struct packed {
		logic [NAXES-1:0][CW-1:0] surf;
		logic                     is_in;
		logic [CW-1:0]            dist_in;
		logic [NAXES-1:0]         ag;       // one-hot axis of largest gap
		logic [NAXES-1:0]         pos;      // p - max > min - p
		logic [NAXES-1:0]         ex_zero;
		logic                     sat;
	} ctx_t;

endpackage

@@ design/aabb_distance_surface_normal.sv @@
// From input accept to m_tvalid: six front stages, a 33-stage square root (one
// root digit per stage, then rounding), a 16-stage divider, an output register.
// Throughput: one item per cycle; the whole pipeline advances when the output is
// free or taken, so a stall on m_tready holds every stage.
// Reset (arst_n low, async): valid bits cleared, box set to [0,1] on each axis.
module aabb_distance_surface_normal import adsn_pkg::*; #(
	parameter int DIMS = 3
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [4:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [95:0]  s_tdata,   // point_x, point_y, point_z
	output logic         m_tvalid,
	input  logic         m_tready,
	// surf_x, surf_y, surf_z, signed_dist, norm_x, norm_y, norm_z
	output logic [175:0] m_tdata,
	output logic [0:0]   m_tuser    // is_inside
);

	localparam int T_SQ_IN   = 6;
	localparam int T_SQ_OUT  = T_SQ_IN + SQ_H + 1;
	localparam int T_DIV_OUT = T_SQ_OUT + DIV_QW;
	localparam int T_OUT     = T_DIV_OUT + 1;

	logic signed [CW-1:0] box_min_q [NAXES];
	logic signed [CW-1:0] box_max_q [NAXES];
	logic en;
	logic [1:T_OUT] vld_q;

	// ---------------- configuration ----------------
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < NAXES; a++) begin
				box_min_q[a] <= '0;
				box_max_q[a] <= 32'sd65536;
			end
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx_t'(paddr[4:2]))
				REG_MIN_X: box_min_q[0] <= pwdata;
				REG_MIN_Y: box_min_q[1] <= pwdata;
				REG_MIN_Z: box_min_q[2] <= pwdata;
				REG_MAX_X: box_max_q[0] <= pwdata;
				REG_MAX_Y: box_max_q[1] <= pwdata;
				REG_MAX_Z: box_max_q[2] <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[4:2]))
			REG_MIN_X: prdata = box_min_q[0];
			REG_MIN_Y: prdata = box_min_q[1];
			REG_MIN_Z: prdata = box_min_q[2];
			REG_MAX_X: prdata = box_max_q[0];
			REG_MAX_Y: prdata = box_max_q[1];
			REG_MAX_Z: prdata = box_max_q[2];
			default:   prdata = '0;
		endcase
	end

	// ---------------- flow control ----------------
	assign en       = m_tready || !m_tvalid;
	assign s_tready = en;
	assign m_tvalid = vld_q[T_OUT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {s_tvalid, vld_q[1:T_OUT-1]};
		end
	end

	// ---------------- stage 1: face gaps ----------------
	logic signed [CW-1:0] p_in [NAXES];
	logic signed [CW-1:0] p_s1 [NAXES];
	logic signed [CW:0]   lo_s1 [NAXES];
	logic signed [CW:0]   hi_s1 [NAXES];
	logic [NAXES-1:0]     below_s1, above_s1;

	always_comb begin
		for (int a = 0; a < NAXES; a++) p_in[a] = s_tdata[a*CW +: CW];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < NAXES; a++) begin
				p_s1[a]     <= p_in[a];
				lo_s1[a]    <= {box_min_q[a][CW-1], box_min_q[a]} - {p_in[a][CW-1], p_in[a]};
				hi_s1[a]    <= {p_in[a][CW-1], p_in[a]} - {box_max_q[a][CW-1], box_max_q[a]};
				below_s1[a] <= p_in[a] < box_min_q[a];
				above_s1[a] <= p_in[a] > box_max_q[a];
			end
		end
	end

	// ---------------- stage 2: inside decision, surface point, excess ----------------
	logic signed [CW:0] gap_c [NAXES];
	logic signed [CW:0] dlo_c [NAXES];
	logic signed [CW:0] dhi_c [NAXES];
	logic [1:0]         amin_c, amax_c, ag_c;
	logic               ins_c, snap_min_c;
	logic [CW-1:0]      ex_c [NAXES];
	ctx_t               ctx_c;
	ctx_t               ctx_s2;
	logic [CW-1:0]      ex_s2 [NAXES];

	always_comb begin
		logic signed [CW:0] g;
		ins_c = 1'b1;
		for (int a = 0; a < NAXES; a++) begin
			gap_c[a] = (lo_s1[a] > hi_s1[a]) ? lo_s1[a] : hi_s1[a];
			dlo_c[a] = -lo_s1[a];
			dhi_c[a] = -hi_s1[a];
			if (a < DIMS && (below_s1[a] || above_s1[a])) ins_c = 1'b0;
		end
		amin_c = '0;
		amax_c = '0;
		ag_c   = '0;
		for (int a = 1; a < NAXES; a++) begin
			if (a < DIMS) begin
				if (dlo_c[a] < dlo_c[amin_c]) amin_c = 2'(a);
				if (dhi_c[a] < dhi_c[amax_c]) amax_c = 2'(a);
				if (gap_c[a] > gap_c[ag_c])   ag_c   = 2'(a);
			end
		end
		snap_min_c = dlo_c[amin_c] <= dhi_c[amax_c];

		ctx_c.is_in = ins_c;
		ctx_c.ag     = NAXES'(1) << ag_c;
		ctx_c.sat    = 1'b0;
		for (int a = 0; a < NAXES; a++) begin
			ctx_c.pos[a] = hi_s1[a] > lo_s1[a];
			if (a < DIMS && gap_c[a] > 0) ex_c[a] = gap_c[a][CW-1:0];
			else                          ex_c[a] = '0;
			ctx_c.ex_zero[a] = (ex_c[a] == '0);
			if (ex_c[a][CW-1]) ctx_c.sat = 1'b1;
			if (a >= DIMS) begin
				ctx_c.surf[a] = '0;
			end else if (ins_c) begin
				if (snap_min_c && 2'(a) == amin_c)       ctx_c.surf[a] = box_min_q[a];
				else if (!snap_min_c && 2'(a) == amax_c) ctx_c.surf[a] = box_max_q[a];
				else                                     ctx_c.surf[a] = p_s1[a];
			end else begin
				if (below_s1[a])      ctx_c.surf[a] = box_min_q[a];
				else if (above_s1[a]) ctx_c.surf[a] = box_max_q[a];
				else                  ctx_c.surf[a] = p_s1[a];
			end
		end
		// inside distance, saturated to 32 bits
		g = gap_c[ag_c];
		if (g[CW] && !g[CW-1])      ctx_c.dist_in = 32'h8000_0000;
		else if (!g[CW] && g[CW-1]) ctx_c.dist_in = 32'h7FFF_FFFF;
		else                        ctx_c.dist_in = g[CW-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s2 <= ctx_c;
			for (int a = 0; a < NAXES; a++) ex_s2[a] <= ex_c[a];
		end
	end

	// ---------------- stage 3: squares, top bit of largest excess ----------------
	logic [2*CW-3:0] sq_s3 [NAXES];
	logic [CW-1:0]   ex_s3 [NAXES];
	logic [4:0]      msb_c, msb_s3;
	logic [CW-1:0]   m_c;

	always_comb begin
		m_c = ex_s2[0];
		for (int a = 1; a < NAXES; a++) if (ex_s2[a] > m_c) m_c = ex_s2[a];
		msb_c = '0;
		for (int i = 0; i < CW; i++) if (m_c[i]) msb_c = 5'(i);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < NAXES; a++) begin
				sq_s3[a] <= (2*CW-2)'(ex_s2[a][CW-2:0]) * (2*CW-2)'(ex_s2[a][CW-2:0]);
				ex_s3[a] <= ex_s2[a];
			end
			msb_s3 <= msb_c;
		end
	end

	// ---------------- stage 4: sum of squares, scaled excess ----------------
	logic [SQ_IW-1:0] s_s4, s_s5, s_s6;
	logic [SC_W-1:0]  sc_s4 [NAXES];

	always_ff @(posedge clk) begin
		if (en) begin
			s_s4 <= SQ_IW'(sq_s3[0]) + SQ_IW'(sq_s3[1]) + SQ_IW'(sq_s3[2]);
			for (int a = 0; a < NAXES; a++) begin
				if (msb_s3 > NORM_MSB) sc_s4[a] <= SC_W'(ex_s3[a] >> (msb_s3 - NORM_MSB));
				else                   sc_s4[a] <= SC_W'(ex_s3[a] << (NORM_MSB - msb_s3));
			end
		end
	end

	// ---------------- stages 5-6: squared length of scaled excess ----------------
	logic [2*SC_W-1:0] sq2_s5 [NAXES];
	logic [2*SC_W+1:0] s2_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < NAXES; a++)
				sq2_s5[a] <= (2*SC_W)'(sc_s4[a]) * (2*SC_W)'(sc_s4[a]);
			s_s5  <= s_s4;
			s2_s6 <= (2*SC_W+2)'(sq2_s5[0]) + (2*SC_W+2)'(sq2_s5[1])
				+ (2*SC_W+2)'(sq2_s5[2]);
			s_s6  <= s_s5;
		end
	end

	// ---------------- square roots ----------------
	logic [SQ_H:0] dlen, nlen;

	adsn_sqrt u_dist_sqrt (
		.clk  (clk),
		.en   (en),
		.rad  (s_s6),
		.root (dlen)
	);

	adsn_sqrt u_norm_sqrt (
		.clk  (clk),
		.en   (en),
		.rad  (SQ_IW'(s2_s6)),
		.root (nlen)
	);

	// ---------------- delay lines ----------------
	ctx_t            ctx_sn [3:T_DIV_OUT];
	logic [SC_W-1:0] sc_sn  [5:T_SQ_OUT][NAXES];
	logic [CW-1:0]   dd_sn  [T_SQ_OUT+1:T_DIV_OUT];

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_sn[3] <= ctx_s2;
			for (int k = 4; k <= T_DIV_OUT; k++) ctx_sn[k] <= ctx_sn[k-1];
			sc_sn[5] <= sc_s4;
			for (int k = 6; k <= T_SQ_OUT; k++) sc_sn[k] <= sc_sn[k-1];
			dd_sn[T_SQ_OUT+1] <= (dlen >= (SQ_H+1)'(33'h0_8000_0000))
				? 32'h7FFF_FFFF : dlen[CW-1:0];
			for (int k = T_SQ_OUT + 2; k <= T_DIV_OUT; k++) dd_sn[k] <= dd_sn[k-1];
		end
	end

	// ---------------- normal division ----------------
	logic [DIV_DW-1:0] den_c;
	logic [DIV_QW-1:0] q_c [NAXES];

	assign den_c = (nlen[DIV_DW-1:0] == '0) ? DIV_DW'(1) : nlen[DIV_DW-1:0];

	for (genvar a = 0; a < NAXES; a++) begin : g_div
		logic [DIV_NW-1:0] num_c;
		assign num_c = DIV_NW'({sc_sn[T_SQ_OUT][a], {NORM_SHIFT{1'b0}}})
			+ DIV_NW'(nlen[DIV_DW-1:1]);
		adsn_div u_div (
			.clk (clk),
			.en  (en),
			.num (num_c),
			.den (den_c),
			.quo (q_c[a])
		);
	end

	// ---------------- output register ----------------
	ctx_t          oc;
	logic [NW-1:0] norm_c [NAXES];
	logic [CW-1:0] dist_c;
	logic [175:0]  odata_s56;
	logic          oins_s56;

	assign oc = ctx_sn[T_DIV_OUT];

	always_comb begin
		logic [NW-1:0] qv;
		for (int a = 0; a < NAXES; a++) begin
			qv = (q_c[a] > NORM_ONE) ? NORM_ONE : q_c[a];
			if (oc.is_in)
				norm_c[a] = oc.ag[a] ? (oc.pos[a] ? NORM_ONE : -NORM_ONE) : '0;
			else if (oc.ex_zero[a])
				norm_c[a] = '0;
			else
				norm_c[a] = oc.pos[a] ? qv : -qv;
		end
		if (oc.is_in)    dist_c = oc.dist_in;
		else if (oc.sat) dist_c = 32'h7FFF_FFFF;
		else             dist_c = dd_sn[T_DIV_OUT];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			odata_s56 <= {norm_c[2], norm_c[1], norm_c[0], dist_c,
				oc.surf[2], oc.surf[1], oc.surf[0]};
			oins_s56  <= oc.is_in;
		end
	end

	assign m_tdata = odata_s56;
	assign m_tuser = oins_s56;

`ifndef SYNTHESIS
	a_inside_one_axis: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |->
		$countones({m_tdata[175:160] != 16'd0, m_tdata[159:144] != 16'd0,
			m_tdata[143:128] != 16'd0}) == 1)
		else $error("inside result must have exactly one normal axis");

	a_inside_dist_nonpos: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[127] || m_tdata[127:96] == 32'd0)
		else $error("inside distance must not be positive");

	a_outside_dist_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> !m_tdata[127])
		else $error("outside distance must not be negative");

	a_norm_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $signed(m_tdata[143:128]) <= 16'sd16384
			&& $signed(m_tdata[143:128]) >= -16'sd16384)
		else $error("normal x out of range");
`endif

endmodule

@@ design/adsn_sqrt.sv @@
// Pipelined rounded integer square root, one root digit per stage, then a registered rounding step.
// Depends on adsn_pkg for widths.
module adsn_sqrt import adsn_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  logic [SQ_IW-1:0] rad,
	output logic [SQ_H:0]    root
);

	localparam int RW = SQ_H + 2;

	logic [RW-1:0]    rem_sn [1:SQ_H];
	logic [SQ_H-1:0]  rt_sn  [1:SQ_H];
	logic [SQ_IW-1:0] rd_sn  [1:SQ_H];
	logic [SQ_H:0]    root_s33;

	for (genvar k = 1; k <= SQ_H; k++) begin : g_step
		logic [RW-1:0]    rem_i;
		logic [SQ_H-1:0]  rt_i;
		logic [SQ_IW-1:0] rd_i;
		logic [RW-1:0]    t;
		logic [RW-1:0]    trial;

		if (k == 1) begin : g_first
			assign rem_i = '0;
			assign rt_i  = '0;
			assign rd_i  = rad;
		end else begin : g_next
			assign rem_i = rem_sn[k-1];
			assign rt_i  = rt_sn[k-1];
			assign rd_i  = rd_sn[k-1];
		end

		assign t     = {rem_i[RW-3:0], rd_i[SQ_IW-1 -: 2]};
		assign trial = {rt_i, 2'b01};

		always_ff @(posedge clk) begin
			if (en) begin
				if (t >= trial) begin
					rem_sn[k] <= t - trial;
					rt_sn[k]  <= {rt_i[SQ_H-2:0], 1'b1};
				end else begin
					rem_sn[k] <= t;
					rt_sn[k]  <= {rt_i[SQ_H-2:0], 1'b0};
				end
				rd_sn[k] <= {rd_i[SQ_IW-3:0], 2'b00};
			end
		end
	end

	// round to nearest: bump when remainder exceeds the root
	always_ff @(posedge clk) begin
		if (en) begin
			root_s33 <= {1'b0, rt_sn[SQ_H]}
				+ (SQ_H+1)'(rem_sn[SQ_H] > {2'b00, rt_sn[SQ_H]});
		end
	end

	assign root = root_s33;

endmodule

@@ design/adsn_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
// Depends on adsn_pkg; expects num[DIV_NW-1:DIV_QW] < den.
module adsn_div import adsn_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [DIV_NW-1:0] num,
	input  logic [DIV_DW-1:0] den,
	output logic [DIV_QW-1:0] quo
);

	logic [DIV_DW-1:0] rem_sn [1:DIV_QW];
	logic [DIV_QW-1:0] nl_sn  [1:DIV_QW];
	logic [DIV_DW-1:0] dn_sn  [1:DIV_QW];
	logic [DIV_QW-1:0] q_sn   [1:DIV_QW];

	for (genvar k = 1; k <= DIV_QW; k++) begin : g_step
		logic [DIV_DW-1:0] rem_i;
		logic [DIV_QW-1:0] nl_i;
		logic [DIV_DW-1:0] dn_i;
		logic [DIV_QW-1:0] q_i;
		logic [DIV_DW:0]   t;
		logic [DIV_DW:0]   d;

		if (k == 1) begin : g_first
			assign rem_i = DIV_DW'(num[DIV_NW-1:DIV_QW]);
			assign nl_i  = num[DIV_QW-1:0];
			assign dn_i  = den;
			assign q_i   = '0;
		end else begin : g_next
			assign rem_i = rem_sn[k-1];
			assign nl_i  = nl_sn[k-1];
			assign dn_i  = dn_sn[k-1];
			assign q_i   = q_sn[k-1];
		end

		assign t = {rem_i, nl_i[DIV_QW-1]};
		assign d = {1'b0, dn_i};

		always_ff @(posedge clk) begin
			if (en) begin
				if (t >= d) begin
					rem_sn[k] <= DIV_DW'(t - d);
					q_sn[k]   <= {q_i[DIV_QW-2:0], 1'b1};
				end else begin
					rem_sn[k] <= t[DIV_DW-1:0];
					q_sn[k]   <= {q_i[DIV_QW-2:0], 1'b0};
				end
				nl_sn[k] <= {nl_i[DIV_QW-2:0], 1'b0};
				dn_sn[k] <= dn_i;
			end
		end
	end

	assign quo = q_sn[DIV_QW];

endmodule
